FILE: design/snot_pkg.sv
// shared types, codes and character constants of the service name owner table
package snot_pkg;

	// request modes
	localparam logic [2:0] MODE_REGISTER   = 3'd0;
	localparam logic [2:0] MODE_LOOKUP     = 3'd1;
	localparam logic [2:0] MODE_REMOVE     = 3'd2;
	localparam logic [2:0] MODE_GRANT      = 3'd3;
	localparam logic [2:0] MODE_REMOVE_PID = 3'd4;
	localparam logic [2:0] MODE_COLLECT    = 3'd5;

	// result status codes
	localparam logic [2:0] STATUS_OK          = 3'd0;
	localparam logic [2:0] STATUS_BAD_NAME    = 3'd1;
	localparam logic [2:0] STATUS_TAKEN       = 3'd2;
	localparam logic [2:0] STATUS_FULL        = 3'd3;
	localparam logic [2:0] STATUS_NOT_FOUND   = 3'd4;
	localparam logic [2:0] STATUS_NOT_OWNER   = 3'd5;
	localparam logic [2:0] STATUS_BAD_GRANTEE = 3'd6;

	// name characters
	localparam logic [7:0] CH_LOWER_A = 8'h61;
	localparam logic [7:0] CH_LOWER_Z = 8'h7a;
	localparam logic [7:0] CH_UPPER_A = 8'h41;
	localparam logic [7:0] CH_UPPER_Z = 8'h5a;
	localparam logic [7:0] CH_DIGIT_0 = 8'h30;
	localparam logic [7:0] CH_DIGIT_9 = 8'h39;
	localparam logic [7:0] CH_UNDER   = 8'h5f;
	localparam logic [7:0] CH_DASH    = 8'h2d;

	typedef struct packed {
		logic [2:0]          mode;
		logic [63:0]         name_key;
		logic signed [31:0]  proc_id;
		logic signed [31:0]  new_owner_id;
		logic [4:0]          copy_limit;
	} req_word_t;

	typedef struct packed {
		logic [2:0]  status;
		logic [30:0] owner_found;
		logic [63:0] owned_name;
		logic [4:0]  owned_count;
		logic        last;
	} rsp_word_t;

	function automatic logic char_ok(input logic [7:0] c);
		return (c >= CH_LOWER_A && c <= CH_LOWER_Z) || (c >= CH_UPPER_A && c <= CH_UPPER_Z) ||
		       (c >= CH_DIGIT_0 && c <= CH_DIGIT_9) || c == CH_UNDER || c == CH_DASH;
	endfunction

endpackage

FILE: design/snot_req_if.sv
// request channel of the service name owner table
interface snot_req_if;
	logic                 valid;
	logic                 ready;
	snot_pkg::req_word_t  payload;

	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

FILE: design/snot_rsp_if.sv
// result channel of the service name owner table
interface snot_rsp_if;
	logic                 valid;
	logic                 ready;
	snot_pkg::rsp_word_t  payload;

	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

FILE: design/service_name_owner_table_unit.sv
// service name owner table: request sequencer, slot scan and slot memory
//
// A table of ENTRIES slots, each holding a service name of up to NAME_BYTES-1
// characters and the pid that owns it. One request word is taken at a time:
// after acceptance the check state tests the name and pids, then a single
// comparator walks the slots in index order, one slot per cycle through the
// registered read port of the slot memory (the first read, one compare per slot
// and a closing step), and the final state writes a new slot for register and
// loads the final word. Requests rejected by the check skip the walk.
// Collect sends one word per owned slot, up to the copy limit, during the walk,
// and the walk waits whenever such a word cannot leave the output register.
// Reset frees all slots at once through per-slot valid bits; no clearing pass
// is needed. Names are stored with every byte after the terminator zeroed.
module service_name_owner_table_unit #(
	parameter int ENTRIES    = 16,
	parameter int NAME_BYTES = 8
) (
	input logic         clk,
	input logic         arst_n,
	snot_req_if.sink    req,
	snot_rsp_if.source  rsp
);

	localparam int NW   = 8 * NAME_BYTES;
	localparam int IW   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
	localparam int CW   = $clog2(ENTRIES + 1);
	localparam int CMPW = (CW > 5) ? CW : 5;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_CHECK,
		ST_SCAN,
		ST_FIN
	} state_t;

	state_t               state_q;
	logic                 out_vld_q;
	snot_pkg::rsp_word_t  out_q;
	logic [ENTRIES-1:0]   vld_q;
	logic                 cmp_vld_q;

	// request fields
	logic [2:0]   mode_q;
	logic [63:0]  key_q;
	logic [31:0]  pid_raw_q;
	logic [31:0]  gnt_raw_q;
	logic [4:0]   lim_q;

	// scan state
	logic [NW-1:0]  canon_q;
	logic [2:0]     st_q;
	logic [30:0]    owner_q;
	logic           run_q;
	logic           hit_q;
	logic           hit_own_q;
	logic           free_f_q;
	logic [IW-1:0]  free_idx_q;
	logic [CW-1:0]  scan_q;
	logic [IW-1:0]  cmp_idx_q;
	logic [CW-1:0]  cnt_q;

	// slot memory
	logic [NW-1:0]  name_mem [ENTRIES];
	logic [30:0]    owner_mem [ENTRIES];
	logic [NW-1:0]  rd_name_q;
	logic [30:0]    rd_owner_q;

	logic [NW-1:0]  canon_c;
	logic           name_ok;
	logic [2:0]     chk_st;
	logic           chk_run;
	logic           pid_ok;
	logic           gnt_ok;
	logic [30:0]    pid;
	logic [30:0]    gnt;
	logic           out_free;
	logic           occ;
	logic           eq;
	logic           own_me;
	logic           m_first;
	logic           collect_hit;
	logic           emit_name;
	logic           advance;
	logic           ev;
	logic           rd_en;
	logic           clr;
	logic           gnt_wr;
	logic           fin_fire;
	logic           ins;
	logic [IW-1:0]  wr_addr;
	logic [30:0]    wr_owner_d;
	logic [2:0]     fin_status;

	assign pid    = pid_raw_q[30:0];
	assign gnt    = gnt_raw_q[30:0];
	assign pid_ok = !pid_raw_q[31] && (|pid_raw_q[30:0]);
	assign gnt_ok = !gnt_raw_q[31] && (|gnt_raw_q[30:0]);

	// name check: stops at the first nul, non-empty, legal characters only
	always_comb begin
		logic [7:0] c;
		logic       term;
		logic       bad;
		c       = '0;
		term    = 1'b0;
		bad     = 1'b0;
		name_ok = 1'b0;
		canon_c = '0;
		for (int i = 0; i < NAME_BYTES; i++) begin
			c = key_q[8*i +: 8];
			if (!term) begin
				if (c == 8'h00) begin
					term    = 1'b1;
					name_ok = (i > 0) && !bad;
				end else begin
					if (!snot_pkg::char_ok(c)) begin
						bad = 1'b1;
					end
					canon_c[8*i +: 8] = c;
				end
			end
		end
	end

	// early outcome of each mode before the walk
	always_comb begin
		chk_st  = snot_pkg::STATUS_NOT_FOUND;
		chk_run = 1'b0;
		case (mode_q)
			snot_pkg::MODE_REGISTER, snot_pkg::MODE_REMOVE: begin
				if (!name_ok || !pid_ok) begin
					chk_st = snot_pkg::STATUS_BAD_NAME;
				end else begin
					chk_run = 1'b1;
				end
			end
			snot_pkg::MODE_LOOKUP: begin
				if (!name_ok) begin
					chk_st = snot_pkg::STATUS_BAD_NAME;
				end else begin
					chk_run = 1'b1;
				end
			end
			snot_pkg::MODE_GRANT: begin
				if (!name_ok || !pid_ok) begin
					chk_st = snot_pkg::STATUS_BAD_NAME;
				end else if (!gnt_ok) begin
					chk_st = snot_pkg::STATUS_BAD_GRANTEE;
				end else begin
					chk_run = 1'b1;
				end
			end
			snot_pkg::MODE_REMOVE_PID: begin
				chk_run = pid_ok;
			end
			snot_pkg::MODE_COLLECT: begin
				chk_run = pid_ok;
				if (pid_ok) begin
					chk_st = snot_pkg::STATUS_OK;
				end
			end
			default: begin
				chk_run = 1'b0;
			end
		endcase
	end

	// slot compare on the word held in the registered read port
	assign out_free    = !out_vld_q || rsp.ready;
	assign occ         = vld_q[cmp_idx_q];
	assign eq          = (rd_name_q == canon_q);
	assign own_me      = (rd_owner_q == pid);
	assign m_first     = occ && eq && !hit_q;
	assign collect_hit = cmp_vld_q && (mode_q == snot_pkg::MODE_COLLECT) && occ && own_me;
	assign emit_name   = collect_hit && (CMPW'(cnt_q) < CMPW'(lim_q));
	assign advance     = !emit_name || out_free;
	assign ev          = (state_q == ST_SCAN) && cmp_vld_q && advance;
	assign rd_en       = (state_q == ST_SCAN) && advance && (scan_q < CW'(ENTRIES));

	assign clr = ev && (((mode_q == snot_pkg::MODE_REMOVE) && m_first && own_me) ||
	                    ((mode_q == snot_pkg::MODE_REMOVE_PID) && occ && own_me));
	assign gnt_wr = ev && (mode_q == snot_pkg::MODE_GRANT) && m_first && own_me;

	// final word and slot insertion for register
	assign fin_fire = (state_q == ST_FIN) && out_free;
	assign ins = fin_fire && run_q && (mode_q == snot_pkg::MODE_REGISTER) && !hit_q && free_f_q;

	always_comb begin
		fin_status = st_q;
		if (run_q && (mode_q == snot_pkg::MODE_REGISTER)) begin
			if (hit_q) begin
				fin_status = hit_own_q ? snot_pkg::STATUS_OK : snot_pkg::STATUS_TAKEN;
			end else if (free_f_q) begin
				fin_status = snot_pkg::STATUS_OK;
			end else begin
				fin_status = snot_pkg::STATUS_FULL;
			end
		end
	end

	assign wr_addr    = ins ? free_idx_q : cmp_idx_q;
	assign wr_owner_d = ins ? pid : gnt;

	assign req.ready   = (state_q == ST_IDLE);
	assign rsp.valid   = out_vld_q;
	assign rsp.payload = out_q;

	// sequencer, valid bits and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			out_vld_q <= 1'b0;
			out_q     <= '0;
			vld_q     <= '0;
			cmp_vld_q <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (req.valid) begin
						state_q <= ST_CHECK;
					end
				end
				ST_CHECK: begin
					cmp_vld_q <= 1'b0;
					state_q   <= chk_run ? ST_SCAN : ST_FIN;
				end
				ST_SCAN: begin
					if (advance) begin
						cmp_vld_q <= rd_en;
					end
					if (!cmp_vld_q && (scan_q == CW'(ENTRIES))) begin
						state_q <= ST_FIN;
					end
				end
				ST_FIN: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase

			if (ev && emit_name) begin
				out_vld_q <= 1'b1;
				out_q     <= '{status: snot_pkg::STATUS_OK, owner_found: '0,
				               owned_name: 64'(rd_name_q), owned_count: '0, last: 1'b0};
			end else if (fin_fire) begin
				out_vld_q         <= 1'b1;
				out_q.status      <= fin_status;
				out_q.owner_found <= owner_q;
				out_q.owned_name  <= '0;
				out_q.owned_count <= 5'(cnt_q);
				out_q.last        <= 1'b1;
			end else if (rsp.ready) begin
				out_vld_q <= 1'b0;
			end

			if (clr) begin
				vld_q[cmp_idx_q] <= 1'b0;
			end
			if (ins) begin
				vld_q[free_idx_q] <= 1'b1;
			end
		end
	end

	// request fields and scan bookkeeping
	always_ff @(posedge clk) begin
		if (req.valid && req.ready) begin
			mode_q    <= req.payload.mode;
			key_q     <= req.payload.name_key;
			pid_raw_q <= req.payload.proc_id;
			gnt_raw_q <= req.payload.new_owner_id;
			lim_q     <= req.payload.copy_limit;
		end
		if (state_q == ST_CHECK) begin
			canon_q   <= canon_c;
			st_q      <= chk_st;
			run_q     <= chk_run;
			owner_q   <= '0;
			hit_q     <= 1'b0;
			hit_own_q <= 1'b0;
			free_f_q  <= 1'b0;
			scan_q    <= '0;
			cnt_q     <= '0;
		end
		if (rd_en) begin
			scan_q    <= scan_q + CW'(1);
			cmp_idx_q <= scan_q[IW-1:0];
		end
		if (ev) begin
			case (mode_q)
				snot_pkg::MODE_REGISTER: begin
					if (!occ) begin
						if (!free_f_q) begin
							free_f_q   <= 1'b1;
							free_idx_q <= cmp_idx_q;
						end
					end else if (eq && !hit_q) begin
						hit_q     <= 1'b1;
						hit_own_q <= own_me;
					end
				end
				snot_pkg::MODE_LOOKUP: begin
					if (m_first) begin
						hit_q   <= 1'b1;
						owner_q <= rd_owner_q;
						st_q    <= snot_pkg::STATUS_OK;
					end
				end
				snot_pkg::MODE_REMOVE: begin
					if (m_first && own_me) begin
						hit_q <= 1'b1;
						st_q  <= snot_pkg::STATUS_OK;
					end
				end
				snot_pkg::MODE_GRANT: begin
					if (m_first) begin
						hit_q <= 1'b1;
						st_q  <= own_me ? snot_pkg::STATUS_OK : snot_pkg::STATUS_NOT_OWNER;
					end
				end
				snot_pkg::MODE_REMOVE_PID: begin
					if (occ && own_me) begin
						st_q <= snot_pkg::STATUS_OK;
					end
				end
				snot_pkg::MODE_COLLECT: begin
					if (collect_hit) begin
						cnt_q <= cnt_q + CW'(1);
					end
				end
				default: begin
					hit_q <= hit_q;
				end
			endcase
		end
	end

	// slot memory: one write port, one registered read port
	always_ff @(posedge clk) begin
		if (ins) begin
			name_mem[wr_addr] <= canon_q;
		end
		if (ins || gnt_wr) begin
			owner_mem[wr_addr] <= wr_owner_d;
		end
		if (rd_en) begin
			rd_name_q  <= name_mem[scan_q[IW-1:0]];
			rd_owner_q <= owner_mem[scan_q[IW-1:0]];
		end
	end

`ifndef SYNTHESIS
	// a non-final word can only be pending while collect walks the slots or closes
	assert property (@(posedge clk) disable iff (!arst_n)
		out_vld_q && !out_q.last |->
			((state_q == ST_SCAN) || (state_q == ST_FIN)) &&
			(mode_q == snot_pkg::MODE_COLLECT))
		else $error("non-final word outside collect walk");

	// register only fills a slot that is free
	assert property (@(posedge clk) disable iff (!arst_n)
		ins |-> !vld_q[free_idx_q])
		else $error("insert into occupied slot");

	// an accepted request is checked in the following cycle
	assert property (@(posedge clk) disable iff (!arst_n)
		req.valid && req.ready |=> state_q == ST_CHECK)
		else $error("accepted request not checked");
`endif

endmodule
